// ===== design/btpc_pkg.sv =====
// btpc_pkg: shared constants, types and arithmetic helpers for the
// barometric compensation pipeline; no dependencies
package btpc_pkg;

    localparam int DivW = 32;

    typedef enum logic [2:0] {
        t_reg_oss  = 3'd0,
        t_reg_ac1  = 3'd1,
        t_reg_ac2  = 3'd2,
        t_reg_ac3  = 3'd3,
        t_reg_ac4  = 3'd4,
        t_reg_b1   = 3'd5,
        t_reg_b2   = 3'd6,
        t_reg_tcal = 3'd7
    } t_reg_idx;

    // division payload carried through the restoring divider
    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] quo;
        logic [31:0] dvs;
        logic        neg;   // negate quotient at the end
        logic        dbl;   // shift quotient left by one at the end
    } t_div;

    // signed truncating divide by 2^k on a 32-bit value
    function automatic logic signed [31:0] sdiv_pow2(input logic signed [31:0] x,
                                                    input int k);
        logic signed [31:0] bias;
        bias = x[31] ? ((32'sd1 <<< k) - 32'sd1) : 32'sd0;
        return (x + bias) >>> k;
    endfunction

endpackage

// ===== design/btpc_div.sv =====
// btpc_div: pipelined restoring divider, one quotient bit per stage
// depends on btpc_pkg
module btpc_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  btpc_pkg::t_div   i_div,
    input  logic [63:0]      i_side,
    output logic             o_valid,
    output btpc_pkg::t_div   o_div,
    output logic [63:0]      o_side
);
    localparam int N = btpc_pkg::DivW;

    btpc_pkg::t_div r_div  [N+1];
    logic [63:0]    r_side [N+1];
    logic           r_vld  [N+1];

    always_comb begin
        r_div[0]  = i_div;
        r_side[0] = i_side;
        r_vld[0]  = i_valid;
    end

    for (genvar s = 0; s < N; s++) begin : g_st
        btpc_pkg::t_div n_div;
        logic [32:0]    trial;
        always_comb begin
            n_div = r_div[s];
            trial = {r_div[s].rem, r_div[s].quo[N-1-s]} - {1'b0, r_div[s].dvs};
            if (!trial[32]) begin
                n_div.rem = trial[31:0];
                n_div.quo[N-1-s] = 1'b1;
            end else begin
                n_div.rem = {r_div[s].rem[30:0], r_div[s].quo[N-1-s]};
                n_div.quo[N-1-s] = 1'b0;
            end
        end
        btpc_pkg::t_div q_div;
        logic [63:0]    q_side;
        logic           q_vld;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                q_vld <= 1'b0;
            end else if (i_en) begin
                q_vld <= r_vld[s];
            end
            if (i_en) begin
                q_div  <= n_div;
                q_side <= r_side[s];
            end
        end
        always_comb begin
            r_div[s+1]  = q_div;
            r_side[s+1] = q_side;
            r_vld[s+1]  = q_vld;
        end
    end

    assign o_valid = r_vld[N];
    assign o_div   = r_div[N];
    assign o_side  = r_side[N];
endmodule

// ===== design/baro_temp_pressure_compensation_top.sv =====
// baro_temp_pressure_compensation_top: integer temperature and pressure
// compensation; depends on btpc_pkg and btpc_div
// 73 register stages; one transaction per cycle sustained while the output
// is not stalled; two 32-stage dividers set the depth; any downstream stall
// freezes the whole pipeline
// synchronous active-low reset clears valid bits and loads register defaults
module baro_temp_pressure_compensation_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // raw_temp[15:0], raw_pressure[34:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // temperature[15:0], pressure[35:16]
    output logic        m_axis_tuser,   // divide_fault[0]
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data
);
    // configuration registers
    logic [1:0]         r_oss;
    logic signed [15:0] r_ac1, r_ac2, r_ac3, r_b1, r_b2;
    logic [15:0]        r_ac4;
    logic [63:0]        r_tcal;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oss <= 2'd3; r_ac1 <= '0; r_ac2 <= '0; r_ac3 <= '0;
            r_ac4 <= '0; r_b1 <= '0; r_b2 <= '0; r_tcal <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                btpc_pkg::t_reg_oss:  r_oss  <= i_cfg_data[1:0];
                btpc_pkg::t_reg_ac1:  r_ac1  <= i_cfg_data[15:0];
                btpc_pkg::t_reg_ac2:  r_ac2  <= i_cfg_data[15:0];
                btpc_pkg::t_reg_ac3:  r_ac3  <= i_cfg_data[15:0];
                btpc_pkg::t_reg_ac4:  r_ac4  <= i_cfg_data[15:0];
                btpc_pkg::t_reg_b1:   r_b1   <= i_cfg_data[15:0];
                btpc_pkg::t_reg_b2:   r_b2   <= i_cfg_data[15:0];
                btpc_pkg::t_reg_tcal: r_tcal <= i_cfg_data;
                default: ;
            endcase
        end
    end

    wire signed [31:0] w_ac5 = {16'd0, r_tcal[15:0]};
    wire signed [31:0] w_ac6 = {16'd0, r_tcal[31:16]};
    wire signed [31:0] w_mc  = {{16{r_tcal[47]}}, r_tcal[47:32]};
    wire signed [31:0] w_md  = {{16{r_tcal[63]}}, r_tcal[63:48]};

    // output register: pipeline advances when output register is free or being taken
    logic r_ov;
    logic w_en;
    assign w_en          = !r_ov || m_axis_tready;
    assign s_axis_tready = w_en;

    // stage 1: (ut - ac6) * ac5
    logic               r1_v;
    logic signed [31:0] r1_prod;
    logic [18:0]        r1_up;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else if (w_en) r1_v <= s_axis_tvalid;
        if (w_en) begin
            r1_prod <= 32'(($signed({16'd0, s_axis_tdata[15:0]}) - w_ac6) * w_ac5);
            r1_up   <= s_axis_tdata[34:16];
        end
    end

    // stage 2: x1 floor shift, denominator, divider setup (signed quotient)
    logic signed [31:0] w2_x1, w2_den, w2_num, w2_dabs;
    btpc_pkg::t_div     w2_div;
    assign w2_x1   = r1_prod >>> 15;
    assign w2_den  = w2_x1 + w_md;
    assign w2_num  = w_mc <<< 11;
    assign w2_dabs = w2_den[31] ? -w2_den : w2_den;
    always_comb begin
        w2_div.rem = '0;
        w2_div.quo = w2_num[31] ? 32'(-w2_num) : w2_num;
        w2_div.dvs = w2_dabs;
        w2_div.neg = w2_num[31] ^ w2_den[31];
        w2_div.dbl = 1'b0;
    end
    // side: x1, up, zero flag
    logic           w2o_v;
    btpc_pkg::t_div w2o_div;
    logic [63:0]    w2o_side;
    btpc_div u_tdiv (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_valid(r1_v), .i_div(w2_div),
        .i_side({12'd0, (w2_den == 32'sd0), r1_up, w2_x1}),
        .o_valid(w2o_v), .o_div(w2o_div), .o_side(w2o_side)
    );

    // stage 3: b5, t, b6
    logic               r3_v, r3_z;
    logic signed [31:0] r3_b6;
    logic signed [27:0] r3_t;
    logic [18:0]        r3_up;
    logic signed [31:0] w3_x2, w3_b5;
    assign w3_x2 = w2o_div.neg ? -$signed(w2o_div.quo) : $signed(w2o_div.quo);
    assign w3_b5 = $signed(w2o_side[31:0]) + w3_x2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else if (w_en) r3_v <= w2o_v;
        if (w_en) begin
            r3_z  <= w2o_side[51];
            r3_up <= w2o_side[50:32];
            r3_t  <= 28'((w3_b5 + 32'sd8) >>> 4);
            r3_b6 <= w3_b5 - 32'sd4000;
        end
    end

    // stage 4: products on b6
    logic               r4_v, r4_z;
    logic signed [31:0] r4_sqp, r4_ac2b6, r4_ac3b6;
    logic signed [27:0] r4_t;
    logic [18:0]        r4_up;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else if (w_en) r4_v <= r3_v;
        if (w_en) begin
            r4_z <= r3_z; r4_t <= r3_t; r4_up <= r3_up;
            r4_sqp   <= 32'(r3_b6 * r3_b6);
            r4_ac2b6 <= 32'(32'(r_ac2) * r3_b6);
            r4_ac3b6 <= 32'(32'(r_ac3) * r3_b6);
        end
    end

    // stage 5: products on sq, scaled b6 products
    logic               r5_v, r5_z;
    logic signed [31:0] r5_b2sq, r5_b1sq, r5_x2a, r5_x1c;
    logic signed [27:0] r5_t;
    logic [18:0]        r5_up;
    logic signed [31:0] w5_sq;
    assign w5_sq = btpc_pkg::sdiv_pow2(r4_sqp, 12);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_v <= 1'b0;
        else if (w_en) r5_v <= r4_v;
        if (w_en) begin
            r5_z <= r4_z; r5_t <= r4_t; r5_up <= r4_up;
            r5_b2sq <= 32'(32'(r_b2) * w5_sq);
            r5_b1sq <= 32'(32'(r_b1) * w5_sq);
            r5_x2a  <= btpc_pkg::sdiv_pow2(r4_ac2b6, 11);
            r5_x1c  <= btpc_pkg::sdiv_pow2(r4_ac3b6, 13);
        end
    end

    // stage 6: b3 and x3 for b4
    logic               r6_v, r6_z;
    logic signed [31:0] r6_b3, r6_x3;
    logic signed [27:0] r6_t;
    logic [18:0]        r6_up;
    logic signed [31:0] w6_x3a, w6_b3a, w6_x3b;
    assign w6_x3a = btpc_pkg::sdiv_pow2(r5_b2sq, 11) + r5_x2a;
    assign w6_b3a = ((32'(r_ac1) <<< 2) + w6_x3a) <<< r_oss;
    assign w6_x3b = r5_x1c + btpc_pkg::sdiv_pow2(r5_b1sq, 16) + 32'sd2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r6_v <= 1'b0;
        else if (w_en) r6_v <= r5_v;
        if (w_en) begin
            r6_z <= r5_z; r6_t <= r5_t; r6_up <= r5_up;
            r6_b3 <= btpc_pkg::sdiv_pow2(w6_b3a + 32'sd2, 2);
            r6_x3 <= btpc_pkg::sdiv_pow2(w6_x3b, 2) + 32'sd32768;
        end
    end

    // stage 7: b4 and b7 products
    logic        r7_v, r7_z;
    logic [31:0] r7_b4, r7_b7;
    logic signed [27:0] r7_t;
    logic [31:0] w7_b4p;
    // only the low 32 bits of ac4 * x3 matter
    assign w7_b4p = {16'd0, r_ac4} * $unsigned(r6_x3);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r7_v <= 1'b0;
        else if (w_en) r7_v <= r6_v;
        if (w_en) begin
            r7_z <= r6_z; r7_t <= r6_t;
            r7_b4 <= {15'd0, w7_b4p[31:15]};
            r7_b7 <= 32'((32'({13'd0, r6_up}) - r6_b3) * (32'd50000 >> r_oss));
        end
    end

    // pressure divider setup
    btpc_pkg::t_div w8_div;
    always_comb begin
        w8_div.rem = '0;
        w8_div.quo = r7_b7[31] ? r7_b7 : {r7_b7[30:0], 1'b0};
        w8_div.dvs = r7_b4;
        w8_div.neg = 1'b0;
        w8_div.dbl = r7_b7[31];
    end
    logic           w8o_v;
    btpc_pkg::t_div w8o_div;
    logic [63:0]    w8o_side;
    btpc_div u_pdiv (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_valid(r7_v), .i_div(w8_div),
        .i_side({35'd0, (r7_z || (r7_b4 == 32'd0)), r7_t}),
        .o_valid(w8o_v), .o_div(w8o_div), .o_side(w8o_side)
    );

    // stage 9: p and its products
    logic               r9_v, r9_z;
    logic signed [31:0] r9_p, r9_psq, r9_pk;
    logic signed [27:0] r9_t;
    logic signed [31:0] w9_p, w9_ps;
    assign w9_p  = w8o_div.dbl ? {w8o_div.quo[30:0], 1'b0} : w8o_div.quo;
    assign w9_ps = btpc_pkg::sdiv_pow2(w9_p, 8);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r9_v <= 1'b0;
        else if (w_en) r9_v <= w8o_v;
        if (w_en) begin
            r9_z <= w8o_side[28]; r9_t <= w8o_side[27:0];
            r9_p   <= w9_p;
            r9_psq <= 32'(w9_ps * w9_ps);
            r9_pk  <= 32'(-32'sd7357 * w9_p);
        end
    end

    // stage 10: x1*3038 and scaled x2
    logic               r10_v, r10_z;
    logic signed [31:0] r10_p, r10_x1, r10_x2;
    logic signed [27:0] r10_t;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r10_v <= 1'b0;
        else if (w_en) r10_v <= r9_v;
        if (w_en) begin
            r10_z <= r9_z; r10_t <= r9_t; r10_p <= r9_p;
            r10_x1 <= 32'(r9_psq * 32'sd3038);
            r10_x2 <= btpc_pkg::sdiv_pow2(r9_pk, 16);
        end
    end

    // stage 11: final sum, saturation, output register
    logic signed [31:0] w11_s, w11_p;
    logic [15:0]        w11_t;
    logic [19:0]        w11_pp;
    assign w11_s = btpc_pkg::sdiv_pow2(r10_x1, 16) + r10_x2 + 32'sd3791;
    assign w11_p = r10_p + btpc_pkg::sdiv_pow2(w11_s, 4);
    always_comb begin
        if (r10_t > 28'sd32767)       w11_t = 16'h7fff;
        else if (r10_t < -28'sd32768) w11_t = 16'h8000;
        else                          w11_t = r10_t[15:0];
        if (w11_p[31])                    w11_pp = '0;
        else if (w11_p > 32'sd1048575)    w11_pp = 20'hfffff;
        else                              w11_pp = w11_p[19:0];
    end

    // a divide fault forces both values to zero and raises the flag
    logic [39:0] r_od;
    logic        r_ouser;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (w_en) r_ov <= r10_v;
        if (w_en) begin
            r_od    <= r10_z ? 40'd0 : {4'd0, w11_pp, w11_t};
            r_ouser <= r10_z;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_od;
    assign m_axis_tuser  = r_ouser;
endmodule

// ===== dv/baro_temp_pressure_compensation_top_tb.sv =====
// testbench for the barometric compensation pipeline: directed and randomized bursty
// stream stimulus against an in-bench integer predictor; depends on btpc_pkg and the top
module baro_temp_pressure_compensation_top_tb;

    localparam int WatchdogLimit = 20000;
    localparam int DrainCycles   = 200;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;    // raw_temp[15:0], raw_pressure[34:16]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;    // temperature[15:0], pressure[35:16]
    logic        m_axis_tuser;    // divide_fault[0]
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [63:0] i_cfg_data;

    typedef struct packed {
        logic signed [15:0] temperature;
        logic [19:0]        pressure;
        logic               divide_fault;
    } t_comp;

    logic [63:0] cal_regs [8];       // shadow copy of the register file
    logic [39:0] raw_queue [$];      // raw pairs waiting for the driver
    t_comp       comp_expected [$];  // compensated results in flight
    int          fail_count = 0;
    int          idle_cycles = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          stall_mode = 0;
    bit          drain_done = 0;

    baro_temp_pressure_compensation_top DUT (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // sign extend a 16-bit word
    function automatic longint sx16(input logic [63:0] v);
        return longint'(signed'(v[15:0]));
    endfunction

    function automatic longint w32(input longint x);
        return longint'(signed'(x[31:0]));
    endfunction

    function automatic longint fdiv(input longint x, input longint d);
        return (x >= 0) ? x / d : -((-x + d - 1) / d);
    endfunction

    // integer compensation, 32-bit wrap at every datasheet step
    function automatic t_comp compensate(input logic [15:0] ut_in,
                                         input logic [18:0] up_in);
        t_comp  r;
        int     oss;
        longint ac1, ac2, ac3, ac4, b1, b2, ac5, ac6, mc, md, ut, up;
        longint x1, x2, x3, den, b5, t, b6, sq, b3, p;
        longint b4, b7, q;
        oss = int'(cal_regs[btpc_pkg::t_reg_oss][1:0]);
        ac1 = sx16(cal_regs[btpc_pkg::t_reg_ac1]);
        ac2 = sx16(cal_regs[btpc_pkg::t_reg_ac2]);
        ac3 = sx16(cal_regs[btpc_pkg::t_reg_ac3]);
        ac4 = longint'(cal_regs[btpc_pkg::t_reg_ac4][15:0]);
        b1  = sx16(cal_regs[btpc_pkg::t_reg_b1]);
        b2  = sx16(cal_regs[btpc_pkg::t_reg_b2]);
        ac5 = longint'(cal_regs[btpc_pkg::t_reg_tcal][15:0]);
        ac6 = longint'(cal_regs[btpc_pkg::t_reg_tcal][31:16]);
        mc  = sx16(cal_regs[btpc_pkg::t_reg_tcal] >> 32);
        md  = sx16(cal_regs[btpc_pkg::t_reg_tcal] >> 48);
        ut  = longint'(ut_in);
        up  = longint'(up_in);
        r = '{temperature: '0, pressure: '0, divide_fault: 1'b1};
        x1 = fdiv(w32((ut - ac6) * ac5), 32768);
        den = w32(x1 + md);
        if (den == 0) return r;
        x2 = w32((mc * 2048) / den);
        b5 = w32(x1 + x2);
        t = fdiv(w32(b5 + 8), 16);
        b6 = w32(b5 - 4000);
        sq = w32(b6 * b6) / 4096;
        x1 = w32(b2 * sq) / 2048;
        x2 = w32(ac2 * b6) / 2048;
        x3 = w32(x1 + x2);
        b3 = w32(w32(ac1 * 4 + x3) * (longint'(1) << oss));
        b3 = w32(b3 + 2) / 4;
        x1 = w32(ac3 * b6) / 8192;
        x2 = w32(b1 * sq) / 65536;
        x3 = w32(x1 + x2 + 2) / 4;
        b4 = ((ac4 * (w32(x3 + 32768) & 64'hFFFF_FFFF)) & 64'hFFFF_FFFF) >> 15;
        if (b4 == 0) return r;
        b7 = (up - (b3 & 64'hFFFF_FFFF)) & 64'hFFFF_FFFF;
        b7 = (b7 * (50000 >> oss)) & 64'hFFFF_FFFF;
        // unsigned divide path picked on bit 31 of b7
        if (b7 < 64'h8000_0000) q = ((b7 * 2) & 64'hFFFF_FFFF) / b4;
        else                    q = ((b7 / b4) * 2) & 64'hFFFF_FFFF;
        p = w32(q);
        x1 = w32((p / 256) * (p / 256));
        x1 = w32(x1 * 3038) / 65536;
        x2 = w32(-7357 * p) / 65536;
        p = w32(p + w32(x1 + x2 + 3791) / 16);
        if (t > 32767) t = 32767;
        if (t < -32768) t = -32768;
        if (p < 0) p = 0;
        if (p > 1048575) p = 1048575;
        r.temperature  = t[15:0];
        r.pressure     = p[19:0];
        r.divide_fault = 1'b0;
        return r;
    endfunction

    // driver: bursts of valid with random gaps, popping the raw queue
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                comp_expected.push_back(compensate(s_axis_tdata[15:0], s_axis_tdata[34:16]));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (raw_queue.size() > 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= raw_queue.pop_front();
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 30);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern: changes mode now and then, mode 0 never stalls
    always @(posedge i_clk) begin
        if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            2: m_axis_tready <= 1'($urandom_range(0, 1));
            default: m_axis_tready <= ($urandom_range(0, 4) == 0);
        endcase
    end

    // monitor: compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin
        t_comp got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{temperature: m_axis_tdata[15:0], pressure: m_axis_tdata[35:16],
                    divide_fault: m_axis_tuser};
            if (comp_expected.size() == 0) begin
                $error("unexpected result transaction %h", m_axis_tdata);
                fail_count++;
            end else begin
                want = comp_expected.pop_front();
                if (got.temperature !== want.temperature) begin
                    $error("temperature exp %0d got %0d", want.temperature, got.temperature);
                    fail_count++;
                end
                if (got.pressure !== want.pressure) begin
                    $error("pressure exp %0d got %0d", want.pressure, got.pressure);
                    fail_count++;
                end
                if (got.divide_fault !== want.divide_fault) begin
                    $error("divide_fault exp %0d got %0d", want.divide_fault,
                           got.divide_fault);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || raw_queue.size() == 0 && comp_expected.size() == 0)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit && !drain_done) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_reg(input btpc_pkg::t_reg_idx idx, input logic [63:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cal_regs[idx] = val & ((idx == btpc_pkg::t_reg_oss) ? 64'h3 :
                              (idx == btpc_pkg::t_reg_tcal) ? '1 : 64'hFFFF);
    endtask

    // wait for the pipeline to empty completely
    task automatic wait_idle();
        int n;
        n = 0;
        while ((raw_queue.size() > 0 || s_axis_tvalid || comp_expected.size() > 0)
               && n < 200000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    // typical datasheet calibration with small perturbations
    task automatic load_typical(input int oss);
        write_reg(btpc_pkg::t_reg_oss, 64'(oss));
        write_reg(btpc_pkg::t_reg_ac1, 64'(16'(408 + $urandom_range(0, 200) - 100)));
        write_reg(btpc_pkg::t_reg_ac2, 64'(16'(-72 + $urandom_range(0, 40) - 20)));
        write_reg(btpc_pkg::t_reg_ac3, 64'(16'(-14383 + $urandom_range(0, 400) - 200)));
        write_reg(btpc_pkg::t_reg_ac4, 64'(16'(32741 + $urandom_range(0, 400) - 200)));
        write_reg(btpc_pkg::t_reg_b1, 64'(16'(6190 + $urandom_range(0, 200) - 100)));
        write_reg(btpc_pkg::t_reg_b2, 64'(16'(4 + $urandom_range(0, 8) - 4)));
        write_reg(btpc_pkg::t_reg_tcal, {16'(2861 + $urandom_range(0, 200) - 100),
                                         16'(-8711 + $urandom_range(0, 400) - 200),
                                         16'(23153 + $urandom_range(0, 400) - 200),
                                         16'(32757 + $urandom_range(0, 400) - 200)});
    endtask

    task automatic load_random();
        write_reg(btpc_pkg::t_reg_oss, 64'($urandom_range(0, 3)));
        for (int i = 1; i < 7; i++)
            write_reg(btpc_pkg::t_reg_idx'(i), 64'($urandom_range(0, 65535)));
        write_reg(btpc_pkg::t_reg_tcal, {$urandom(), $urandom()});
    endtask

    task automatic push_raw(input logic [15:0] ut, input logic [18:0] up);
        raw_queue.push_back({5'b0, up, ut});
    endtask

    initial begin
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        cal_regs = '{64'd3, 0, 0, 0, 0, 0, 0, 0};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: all calibration words zero, so the temperature divisor is zero
        push_raw(16'h0000, 19'h00000);
        push_raw(16'hFFFF, 19'h7FFFF);
        wait_idle();

        // directed: typical calibration, extremes of the raw fields
        load_typical(3);
        push_raw(16'd27898, 19'd23843 << 3);
        push_raw(16'h0000, 19'h00000);
        push_raw(16'hFFFF, 19'h7FFFF);
        push_raw(16'h8000, 19'h40000);
        push_raw(16'h7FFF, 19'h3FFFF);
        push_raw(16'h0000, 19'h7FFFF);
        push_raw(16'hFFFF, 19'h00000);
        wait_idle();
        // zero temperature divisor: ac5 zero makes x1 zero, md zero
        write_reg(btpc_pkg::t_reg_tcal, {16'd0, 16'd1234, 16'd1000, 16'd0});
        push_raw(16'd500, 19'd1000);
        wait_idle();
        // zero pressure divisor: ac4 zero
        load_typical(0);
        write_reg(btpc_pkg::t_reg_ac4, 64'd0);
        push_raw(16'd27898, 19'd23843);
        wait_idle();
        // saturation: extreme signed calibration words
        write_reg(btpc_pkg::t_reg_oss, 64'd1);
        write_reg(btpc_pkg::t_reg_ac4, 64'hFFFF);
        write_reg(btpc_pkg::t_reg_ac1, 64'h8000);
        write_reg(btpc_pkg::t_reg_tcal, {16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF});
        push_raw(16'hFFFF, 19'h7FFFF);
        push_raw(16'h0000, 19'h00000);
        wait_idle();
        write_reg(btpc_pkg::t_reg_ac1, 64'h7FFF);
        wait_idle();
        push_raw(16'h1234, 19'h12345);
        wait_idle();

        // random phases: mostly realistic calibration, some fully random words
        for (int ph = 0; ph < 12; ph++) begin
            if (ph % 3 == 2) load_random();
            else load_typical(ph % 4);
            for (int k = 0; k < 95; k++) begin
                if ($urandom_range(0, 3) == 0)
                    push_raw(16'($urandom_range(0, 65535)),
                             19'($urandom_range(0, 524287)));
                else
                    push_raw(16'($urandom_range(20000, 36000)),
                             19'($urandom_range(20000, 30000) << (ph % 4)));
            end
            wait_idle();
        end

        drain_done = 1;
        if (fail_count == 0 && comp_expected.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
design/btpc_pkg.sv
design/btpc_div.sv
design/baro_temp_pressure_compensation_top.sv
dv/baro_temp_pressure_compensation_top_tb.sv
